// ===== sv/cafm_pkg.sv =====
// ----------------------------------------------------------------------------
// cafm_pkg
// Types and constants shared by the acknowledgement frame matcher modules.
// ----------------------------------------------------------------------------
package cafm_pkg;

    // Frame parsing phases, one per byte position of the frame; all value bytes share one
    typedef enum logic [3:0] {
        PH_HDR0  = 4'd0,
        PH_HDR1  = 4'd1,
        PH_HDR2  = 4'd2,
        PH_HDR3  = 4'd3,
        PH_LEN0  = 4'd4,
        PH_LEN1  = 4'd5,
        PH_CMD0  = 4'd6,
        PH_CMD1  = 4'd7,
        PH_RES0  = 4'd8,
        PH_RES1  = 4'd9,
        PH_VALUE = 4'd10,
        PH_TAIL0 = 4'd11,
        PH_TAIL1 = 4'd12,
        PH_TAIL2 = 4'd13,
        PH_TAIL3 = 4'd14
    } phase_t;

    // Header and tail byte patterns
    localparam logic [7:0] HDR_BYTE0  = 8'hFD;
    localparam logic [7:0] HDR_BYTE1  = 8'hFC;
    localparam logic [7:0] HDR_BYTE2  = 8'hFB;
    localparam logic [7:0] HDR_BYTE3  = 8'hFA;
    localparam logic [7:0] TAIL_BYTE0 = 8'h04;
    localparam logic [7:0] TAIL_BYTE1 = 8'h03;
    localparam logic [7:0] TAIL_BYTE2 = 8'h02;
    localparam logic [7:0] TAIL_BYTE3 = 8'h01;

    // Acknowledge flag ORed into the echoed command
    localparam logic [15:0] ACK_FLAG    = 16'h0100;
    // Payload bytes taken by echoed command and result
    localparam logic [15:0] MIN_PAYLOAD = 16'd4;

    // One result beat
    typedef struct packed {
        logic [7:0]  value_byte;
        logic        value_valid;
        logic        frame_done;
        logic        ack_found;
        logic [15:0] value_length;
        logic        in_frame;
    } result_t;

endpackage

// ===== sv/cafm_parser.sv =====
// ----------------------------------------------------------------------------
// cafm_parser
// Byte-wide frame state machine: checks one received byte against the current
// phase, produces that byte's result and advances the phase on each step.
// ----------------------------------------------------------------------------
module cafm_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    input  logic [15:0]       ack_word,
    output cafm_pkg::result_t result
);

    cafm_pkg::phase_t phase_reg;
    cafm_pkg::phase_t phase_next;
    logic [15:0]      remaining_reg;
    logic [15:0]      remaining_next;
    logic [15:0]      length_reg;
    logic [15:0]      length_next;

    logic [15:0]      full_length;
    logic [15:0]      value_count;
    logic [15:0]      remaining_dec;
    logic             first_hdr;

    // Hold state between accepted bytes, advance on each step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= cafm_pkg::PH_HDR0;
            remaining_reg <= '0;
            length_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            length_reg    <= length_next;
        end
    end

    assign full_length   = {rx_byte, length_reg[7:0]};
    assign value_count   = length_reg - cafm_pkg::MIN_PAYLOAD;
    assign remaining_dec = (remaining_reg != 16'd0) ? remaining_reg - 16'd1 : 16'd0;
    assign first_hdr     = (rx_byte == cafm_pkg::HDR_BYTE0);

    // Next phase and per-byte result
    always_comb
    begin
        phase_next     = cafm_pkg::PH_HDR0;
        remaining_next = remaining_reg;
        length_next    = length_reg;
        result         = '0;
        result.in_frame = 1'b1;

        case (phase_reg)
            cafm_pkg::PH_HDR1:
            begin
                result.in_frame = 1'b0;
                if (rx_byte == cafm_pkg::HDR_BYTE1)
                    phase_next = cafm_pkg::PH_HDR2;
                else
                    phase_next = first_hdr ? cafm_pkg::PH_HDR1 : cafm_pkg::PH_HDR0;
            end
            cafm_pkg::PH_HDR2:
            begin
                result.in_frame = 1'b0;
                if (rx_byte == cafm_pkg::HDR_BYTE2)
                    phase_next = cafm_pkg::PH_HDR3;
                else
                    phase_next = first_hdr ? cafm_pkg::PH_HDR1 : cafm_pkg::PH_HDR0;
            end
            cafm_pkg::PH_HDR3:
            begin
                if (rx_byte == cafm_pkg::HDR_BYTE3)
                begin
                    phase_next = cafm_pkg::PH_LEN0;
                end
                else
                begin
                    result.in_frame = 1'b0;
                    phase_next = first_hdr ? cafm_pkg::PH_HDR1 : cafm_pkg::PH_HDR0;
                end
            end
            cafm_pkg::PH_LEN0:
            begin
                length_next = {8'd0, rx_byte};
                phase_next  = cafm_pkg::PH_LEN1;
            end
            cafm_pkg::PH_LEN1:
            begin
                length_next = full_length;
                if (full_length < cafm_pkg::MIN_PAYLOAD)
                    result.frame_done = 1'b1;
                else
                    phase_next = cafm_pkg::PH_CMD0;
            end
            cafm_pkg::PH_CMD0:
            begin
                if (rx_byte == ack_word[7:0])
                    phase_next = cafm_pkg::PH_CMD1;
                else
                    result.frame_done = 1'b1;
            end
            cafm_pkg::PH_CMD1:
            begin
                if (rx_byte == ack_word[15:8])
                    phase_next = cafm_pkg::PH_RES0;
                else
                    result.frame_done = 1'b1;
            end
            cafm_pkg::PH_RES0:
            begin
                if (rx_byte == 8'd0)
                    phase_next = cafm_pkg::PH_RES1;
                else
                    result.frame_done = 1'b1;
            end
            cafm_pkg::PH_RES1:
            begin
                if (rx_byte == 8'd0)
                begin
                    remaining_next = value_count;
                    phase_next = (value_count != 16'd0) ? cafm_pkg::PH_VALUE
                                                        : cafm_pkg::PH_TAIL0;
                end
                else
                begin
                    result.frame_done = 1'b1;
                end
            end
            cafm_pkg::PH_VALUE:
            begin
                result.value_byte  = rx_byte;
                result.value_valid = 1'b1;
                remaining_next     = remaining_dec;
                phase_next = (remaining_dec != 16'd0) ? cafm_pkg::PH_VALUE
                                                      : cafm_pkg::PH_TAIL0;
            end
            cafm_pkg::PH_TAIL0:
            begin
                if (rx_byte == cafm_pkg::TAIL_BYTE0)
                    phase_next = cafm_pkg::PH_TAIL1;
                else
                    result.frame_done = 1'b1;
            end
            cafm_pkg::PH_TAIL1:
            begin
                if (rx_byte == cafm_pkg::TAIL_BYTE1)
                    phase_next = cafm_pkg::PH_TAIL2;
                else
                    result.frame_done = 1'b1;
            end
            cafm_pkg::PH_TAIL2:
            begin
                if (rx_byte == cafm_pkg::TAIL_BYTE2)
                    phase_next = cafm_pkg::PH_TAIL3;
                else
                    result.frame_done = 1'b1;
            end
            cafm_pkg::PH_TAIL3:
            begin
                result.frame_done = 1'b1;
                if (rx_byte == cafm_pkg::TAIL_BYTE3)
                begin
                    result.ack_found    = 1'b1;
                    result.value_length = value_count;
                end
            end
            default:
            begin
                // Hunting for the first header byte; unused codes land here too
                result.in_frame = 1'b0;
                phase_next = first_hdr ? cafm_pkg::PH_HDR1 : cafm_pkg::PH_HDR0;
            end
        endcase
    end

endmodule

// ===== sv/config_ack_frame_matcher.sv =====
// ----------------------------------------------------------------------------
// config_ack_frame_matcher
// Recognises acknowledgement frames in a received byte stream.
// ----------------------------------------------------------------------------
// Takes one received byte per beat and returns exactly one result beat for it:
// value bytes of a frame that has passed every check so far, a frame_done
// marker with the verdict (ack_found, value_length) at the byte that ends a
// candidate frame, and in_frame while inside one. A byte goes through
// combinational logic between the phase registers and the result register,
// so a new byte is taken every cycle while the result register is empty or
// being drained; its result beat is presented in the cycle after the input
// beat. The expected command is written through the cfg port, which is always
// ready, and should only be changed while no byte is in flight.
// ----------------------------------------------------------------------------
module config_ack_frame_matcher (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] expected_command,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  value_byte,
    output logic        value_valid,
    output logic        frame_done,
    output logic        ack_found,
    output logic [15:0] value_length,
    output logic        in_frame
);

    logic [15:0]       command_reg;
    logic              out_valid_reg;
    cafm_pkg::result_t result_reg;
    cafm_pkg::result_t step_result;
    logic              in_beat;
    logic [15:0]       ack_word;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_beat   = in_valid && in_ready;
    assign ack_word  = command_reg | cafm_pkg::ACK_FLAG;

    // Hold the expected command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            command_reg <= '0;
        else if (cfg_valid)
            command_reg <= expected_command;
    end

    // Check each byte and advance the frame phase
    cafm_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (in_beat),
        .rx_byte  (rx_byte),
        .ack_word (ack_word),
        .result   (step_result)
    );

    // Result register: load on an input beat, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_beat)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
            result_reg <= step_result;
    end

    assign out_valid    = out_valid_reg;
    assign value_byte   = result_reg.value_byte;
    assign value_valid  = result_reg.value_valid;
    assign frame_done   = result_reg.frame_done;
    assign ack_found    = result_reg.ack_found;
    assign value_length = result_reg.value_length;
    assign in_frame     = result_reg.in_frame;

endmodule

// ===== tb/cafm_checker.sv =====
// ----------------------------------------------------------------------------
// cafm_checker
// Predicts and checks the result beats of the acknowledgement frame matcher.
// ----------------------------------------------------------------------------
// Watches the configuration, input and output channels of the matcher. The
// parser state is tracked per accepted input beat. One result is predicted
// for each input beat and queued. Every output beat is compared field by
// field with the oldest queued result. The mismatch count and the number of
// results still awaited are handed back to the testbench top.
// ----------------------------------------------------------------------------
module cafm_checker (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] expected_command,

    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  rx_byte,

    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  value_byte,
    input  logic        value_valid,
    input  logic        frame_done,
    input  logic        ack_found,
    input  logic [15:0] value_length,
    input  logic        in_frame,

    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] HDR_SEQ  = {cafm_pkg::HDR_BYTE3, cafm_pkg::HDR_BYTE2,
                                        cafm_pkg::HDR_BYTE1, cafm_pkg::HDR_BYTE0};
    localparam logic [31:0] TAIL_SEQ = {cafm_pkg::TAIL_BYTE3, cafm_pkg::TAIL_BYTE2,
                                        cafm_pkg::TAIL_BYTE1, cafm_pkg::TAIL_BYTE0};

    // Mirror of the parser state and the awaited command
    cafm_pkg::phase_t  match_phase;
    logic [15:0]       value_left;
    logic [15:0]       payload_length;
    logic [15:0]       await_cmd;

    cafm_pkg::result_t ack_results_q[$];

    // Print one line per mismatch and count it
    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Advance the parser mirror by one received byte and give its result beat
    task automatic match_byte(input logic [7:0] b, output cafm_pkg::result_t r);
        logic [15:0]      ack;
        logic [1:0]       pos;
        cafm_pkg::phase_t nxt;
        ack         = await_cmd | cafm_pkg::ACK_FLAG;
        r           = '0;
        r.in_frame  = 1'b1;
        nxt         = cafm_pkg::PH_HDR0;
        case (match_phase)
            cafm_pkg::PH_HDR1, cafm_pkg::PH_HDR2, cafm_pkg::PH_HDR3:
            begin
                r.in_frame = 1'b0;
                pos        = match_phase[1:0];
                if (b == HDR_SEQ[8*pos +: 8])
                begin
                    nxt = cafm_pkg::phase_t'(match_phase + 1);
                    if (nxt == cafm_pkg::PH_LEN0)
                        r.in_frame = 1'b1;
                end
                else
                    nxt = (b == cafm_pkg::HDR_BYTE0) ? cafm_pkg::PH_HDR1 : cafm_pkg::PH_HDR0;
            end
            cafm_pkg::PH_LEN0:
            begin
                payload_length = {8'h00, b};
                nxt            = cafm_pkg::PH_LEN1;
            end
            cafm_pkg::PH_LEN1:
            begin
                payload_length[15:8] = b;
                if (payload_length < cafm_pkg::MIN_PAYLOAD)
                    r.frame_done = 1'b1;
                else
                    nxt = cafm_pkg::PH_CMD0;
            end
            cafm_pkg::PH_CMD0:
            begin
                if (b == ack[7:0])
                    nxt = cafm_pkg::PH_CMD1;
                else
                    r.frame_done = 1'b1;
            end
            cafm_pkg::PH_CMD1:
            begin
                if (b == ack[15:8])
                    nxt = cafm_pkg::PH_RES0;
                else
                    r.frame_done = 1'b1;
            end
            cafm_pkg::PH_RES0:
            begin
                if (b == 8'h00)
                    nxt = cafm_pkg::PH_RES1;
                else
                    r.frame_done = 1'b1;
            end
            cafm_pkg::PH_RES1:
            begin
                if (b == 8'h00)
                begin
                    value_left = payload_length - cafm_pkg::MIN_PAYLOAD;
                    nxt        = (value_left != 16'd0) ? cafm_pkg::PH_VALUE
                                                       : cafm_pkg::PH_TAIL0;
                end
                else
                    r.frame_done = 1'b1;
            end
            cafm_pkg::PH_VALUE:
            begin
                r.value_byte  = b;
                r.value_valid = 1'b1;
                if (value_left != 16'd0)
                    value_left = value_left - 16'd1;
                nxt = (value_left != 16'd0) ? cafm_pkg::PH_VALUE : cafm_pkg::PH_TAIL0;
            end
            cafm_pkg::PH_TAIL0, cafm_pkg::PH_TAIL1, cafm_pkg::PH_TAIL2, cafm_pkg::PH_TAIL3:
            begin
                pos = 2'(match_phase - cafm_pkg::PH_TAIL0);
                if (b == TAIL_SEQ[8*pos +: 8])
                begin
                    if (match_phase == cafm_pkg::PH_TAIL3)
                    begin
                        r.frame_done   = 1'b1;
                        r.ack_found    = 1'b1;
                        r.value_length = payload_length - cafm_pkg::MIN_PAYLOAD;
                    end
                    else
                        nxt = cafm_pkg::phase_t'(match_phase + 1);
                end
                else
                    r.frame_done = 1'b1;
            end
            default:
            begin
                // Hunting the first header byte
                r.in_frame = 1'b0;
                nxt        = (b == cafm_pkg::HDR_BYTE0) ? cafm_pkg::PH_HDR1 : cafm_pkg::PH_HDR0;
            end
        endcase
        match_phase = nxt;
    endtask

    // Check output beats, queue predictions for input beats, track configuration
    always @(posedge clk or negedge rst_n)
    begin
        cafm_pkg::result_t got;
        cafm_pkg::result_t want;
        if (!rst_n)
        begin
            match_phase    = cafm_pkg::PH_HDR0;
            value_left     = '0;
            payload_length = '0;
            await_cmd      = '0;
            ack_results_q.delete();
            mismatches     = 0;
            outstanding    <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.value_byte   = value_byte;
                got.value_valid  = value_valid;
                got.frame_done   = frame_done;
                got.ack_found    = ack_found;
                got.value_length = value_length;
                got.in_frame     = in_frame;
                if (ack_results_q.size() == 0)
                    report("result beat with nothing awaited, value_byte",
                           {8'h00, got.value_byte}, 16'd0);
                else
                begin
                    want = ack_results_q.pop_front();
                    if (got.value_byte !== want.value_byte)
                        report("value_byte", {8'h00, got.value_byte},
                               {8'h00, want.value_byte});
                    if (got.value_valid !== want.value_valid)
                        report("value_valid", {15'd0, got.value_valid},
                               {15'd0, want.value_valid});
                    if (got.frame_done !== want.frame_done)
                        report("frame_done", {15'd0, got.frame_done},
                               {15'd0, want.frame_done});
                    if (got.ack_found !== want.ack_found)
                        report("ack_found", {15'd0, got.ack_found},
                               {15'd0, want.ack_found});
                    if (got.value_length !== want.value_length)
                        report("value_length", got.value_length, want.value_length);
                    if (got.in_frame !== want.in_frame)
                        report("in_frame", {15'd0, got.in_frame},
                               {15'd0, want.in_frame});
                end
            end

            if (in_valid && in_ready)
            begin
                match_byte(rx_byte, want);
                ack_results_q.push_back(want);
            end

            // A write at this edge applies from the next accepted byte on
            if (cfg_valid && cfg_ready)
                await_cmd = expected_command;

            outstanding <= ack_results_q.size();
        end
    end

endmodule

// ===== tb/tb_config_ack_frame_matcher.sv =====
// ----------------------------------------------------------------------------
// tb_config_ack_frame_matcher
// Testbench top for the acknowledgement frame matcher.
// ----------------------------------------------------------------------------
// Feeds the matcher a short directed byte sequence, then random frames: mostly
// well-formed acknowledgements with random value bytes, the rest broken at the
// header, length, echoed command, result or tail, plus stray noise bytes. The
// run goes through four idling phases, each under a new expected command that
// is written in the middle of a frame while no byte is in flight. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_config_ack_frame_matcher;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] HDR_SEQ  = {cafm_pkg::HDR_BYTE3, cafm_pkg::HDR_BYTE2,
                                        cafm_pkg::HDR_BYTE1, cafm_pkg::HDR_BYTE0};
    localparam logic [31:0] TAIL_SEQ = {cafm_pkg::TAIL_BYTE3, cafm_pkg::TAIL_BYTE2,
                                        cafm_pkg::TAIL_BYTE1, cafm_pkg::TAIL_BYTE0};

    // Ways a random frame is spoilt
    typedef enum int {
        F_NONE,
        F_SHORT,
        F_CMD_LO,
        F_CMD_HI,
        F_RES_LO,
        F_RES_HI,
        F_TAIL,
        F_HEADER,
        F_NOISE
    } frame_fault_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] expected_command;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  value_byte;
    logic        value_valid;
    logic        frame_done;
    logic        ack_found;
    logic [15:0] value_length;
    logic        in_frame;

    int          mismatches;
    int          outstanding;
    int          tx_idle_pct  = 0;
    int          rx_stall_pct = 0;
    int          bytes_sent   = 0;
    logic [15:0] cur_cmd      = '0;

    config_ack_frame_matcher DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .expected_command (expected_command),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .value_byte       (value_byte),
        .value_valid      (value_valid),
        .frame_done       (frame_done),
        .ack_found        (ack_found),
        .value_length     (value_length),
        .in_frame         (in_frame)
    );

    cafm_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .expected_command (expected_command),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .value_byte       (value_byte),
        .value_valid      (value_valid),
        .frame_done       (frame_done),
        .ack_found        (ack_found),
        .value_length     (value_length),
        .in_frame         (in_frame),
        .mismatches       (mismatches),
        .outstanding      (outstanding)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up well past the slowest correct run
    initial
    begin
        #(2_000_000);
        $display("FAIL");
        $finish;
    end

    // Stall the result channel at the current rate
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Offer one byte, after a random idle gap, and hold it until taken
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    // Drop valid and wait until every awaited result beat has arrived
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Write the expected command register
    task automatic write_cmd(input logic [15:0] v);
        cfg_valid        <= 1'b1;
        expected_command <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_cmd = v;
    endtask

    // Send one random frame; big_vlen above zero forces a good frame that long
    task automatic send_frame(input int big_vlen);
        logic [7:0]   fb[$];
        frame_fault_t fault;
        logic [15:0]  echo;
        logic [15:0]  flen;
        logic [7:0]   nz;
        int           vlen;
        int           cut;
        int           n;
        echo = cur_cmd | cafm_pkg::ACK_FLAG;
        nz   = 8'($urandom_range(1, 255));
        vlen = 0;
        flen = '0;
        if (big_vlen > 0)
            fault = F_NONE;
        else if ($urandom_range(99) < 60)
            fault = F_NONE;
        else
            fault = frame_fault_t'($urandom_range(F_SHORT, F_NOISE));

        if (fault == F_NOISE)
        begin
            n = $urandom_range(1, 4);
            repeat (n) fb.push_back(8'($urandom_range(255)));
        end
        else if (fault == F_HEADER)
        begin
            // Partial header, then a breaking byte that may itself restart it
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
                fb.push_back(HDR_SEQ[8*i +: 8]);
            fb.push_back($urandom_range(1) ? cafm_pkg::HDR_BYTE0
                                           : (HDR_SEQ[8*n +: 8] ^ nz));
        end
        else
        begin
            if (fault == F_NONE || fault == F_TAIL)
            begin
                if (big_vlen > 0)
                    vlen = big_vlen;
                else if ($urandom_range(9) == 0)
                    vlen = $urandom_range(9, 64);
                else
                    vlen = $urandom_range(0, 8);
                flen = 16'(vlen + 4);
            end
            else if (fault == F_SHORT)
                flen = 16'($urandom_range(0, 3));
            else
                flen = 16'($urandom_range(4, 65535));

            for (int i = 0; i < 4; i++)
                fb.push_back(HDR_SEQ[8*i +: 8]);
            fb.push_back(flen[7:0]);
            fb.push_back(flen[15:8]);
            fb.push_back(echo[7:0]);
            fb.push_back(echo[15:8]);
            fb.push_back(8'h00);
            fb.push_back(8'h00);
            repeat (vlen) fb.push_back(8'($urandom_range(255)));
            for (int i = 0; i < 4; i++)
                fb.push_back(TAIL_SEQ[8*i +: 8]);

            // Spoil the chosen byte and drop everything after it
            case (fault)
                F_SHORT:  cut = 5;
                F_CMD_LO: cut = 6;
                F_CMD_HI: cut = 7;
                F_RES_LO: cut = 8;
                F_RES_HI: cut = 9;
                F_TAIL:   cut = 10 + vlen + $urandom_range(0, 3);
                default:  cut = fb.size() - 1;
            endcase
            if (fault != F_SHORT && fault != F_NONE)
                fb[cut] = fb[cut] ^ nz;
            while (fb.size() > cut + 1)
                void'(fb.pop_back());
        end

        foreach (fb[i])
            send_byte(fb[i]);
    endtask

    // Start a good frame, change the command mid-frame while idle, finish it
    task automatic retarget(input logic [15:0] new_cmd);
        logic [15:0] echo;
        int          vlen;
        vlen = $urandom_range(0, 6);
        for (int i = 0; i < 4; i++)
            send_byte(HDR_SEQ[8*i +: 8]);
        send_byte(8'(vlen + 4));
        send_byte(8'h00);
        drain();
        write_cmd(new_cmd);
        echo = new_cmd | cafm_pkg::ACK_FLAG;
        send_byte(echo[7:0]);
        send_byte(echo[15:8]);
        send_byte(8'h00);
        send_byte(8'h00);
        repeat (vlen) send_byte(8'($urandom_range(255)));
        for (int i = 0; i < 4; i++)
            send_byte(TAIL_SEQ[8*i +: 8]);
    endtask

    // Main stimulus
    initial
    begin
        logic [7:0]  directed_q[$];
        logic [15:0] phase_cmd[4];
        int          idle_pcts[4];
        int          stall_pcts[4];
        int          start;
        int          frames;

        rst_n            <= 1'b0;
        cfg_valid        <= 1'b0;
        expected_command <= '0;
        in_valid         <= 1'b0;
        rx_byte          <= '0;

        phase_cmd  = '{16'hFFFF, 16'h0000,
                       16'($urandom_range(65535)) & ~cafm_pkg::ACK_FLAG,
                       16'($urandom_range(65535)) | cafm_pkg::ACK_FLAG};
        idle_pcts  = '{0, 79, 0, 13};
        stall_pcts = '{0, 0, 79, 13};

        // Hold reset low, then release it
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Byte extremes, header restart on a repeated first byte, an accepted
        // frame with no value bytes under the reset command, a zero length
        directed_q = '{8'h00, 8'hFF,
                       cafm_pkg::HDR_BYTE0, cafm_pkg::HDR_BYTE0, cafm_pkg::HDR_BYTE1,
                       cafm_pkg::HDR_BYTE2, cafm_pkg::HDR_BYTE3,
                       8'h04, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00,
                       cafm_pkg::TAIL_BYTE0, cafm_pkg::TAIL_BYTE1, cafm_pkg::TAIL_BYTE2,
                       cafm_pkg::TAIL_BYTE3,
                       cafm_pkg::HDR_BYTE0, cafm_pkg::HDR_BYTE1, cafm_pkg::HDR_BYTE2,
                       cafm_pkg::HDR_BYTE3, 8'h00, 8'h00};
        foreach (directed_q[i])
            send_byte(directed_q[i]);
        drain();

        // Random frames, one idling phase per expected command
        for (int p = 0; p < 4; p++)
        begin
            retarget(phase_cmd[p]);
            tx_idle_pct  = idle_pcts[p];
            rx_stall_pct = stall_pcts[p];
            start  = bytes_sent;
            frames = 0;
            while (bytes_sent - start < 300)
            begin
                send_frame((p == 0 && frames == 3) ? 300 : 0);
                frames++;
                // Pause the sender at the fifth frame of a phase until all results are in
                if (frames == 5)
                    drain();
            end
        end

        drain();
        repeat (4) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/cafm_pkg.sv
sv/cafm_parser.sv
sv/config_ack_frame_matcher.sv
tb/cafm_checker.sv
tb/tb_config_ack_frame_matcher.sv
